FILE: sv/sv3d_pkg.sv
package sv3d_pkg;

  localparam int MAG_W   = 14;
  localparam int DIG_W   = 4;
  localparam int STEP_W  = 3;

  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(9999);
  localparam logic [MAG_W-1:0] K_1000    = MAG_W'(1000);
  localparam logic [MAG_W-1:0] K_100     = MAG_W'(100);
  localparam logic [MAG_W-1:0] K_10      = MAG_W'(10);
  localparam logic [DIG_W-1:0] BLANK_CODE = DIG_W'(10);

  // datapath operations
  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_EMIT = 2'd3;

  // subtrahend / digit select
  localparam logic [1:0] SEL_1000 = 2'd0;
  localparam logic [1:0] SEL_100  = 2'd1;
  localparam logic [1:0] SEL_10   = 2'd2;

  // branch conditions
  localparam logic [1:0] COND_NEXT    = 2'd0;
  localparam logic [1:0] COND_JUMP    = 2'd1;
  localparam logic [1:0] COND_NOSTART = 2'd2;
  localparam logic [1:0] COND_GE      = 2'd3;

  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);

  typedef struct packed {
    logic signed [14:0] value;
    logic               is_tenths;
  } in_t;

  typedef struct packed {
    logic             minus_on;
    logic [DIG_W-1:0] hundreds_code;
    logic [DIG_W-1:0] tens_code;
    logic [DIG_W-1:0] ones_digit;
    logic             point_on;
    logic             degree_on;
    logic             celsius_on;
  } out_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        sel;
    logic [1:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic ge;
  } stat_t;

  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      3'd0:    w = '{op: OP_LOAD, sel: SEL_1000, cond: COND_NOSTART, target: 3'd0};
      3'd1:    w = '{op: OP_SUB,  sel: SEL_1000, cond: COND_GE,      target: 3'd1};
      3'd2:    w = '{op: OP_SUB,  sel: SEL_100,  cond: COND_GE,      target: 3'd2};
      3'd3:    w = '{op: OP_SUB,  sel: SEL_10,   cond: COND_GE,      target: 3'd3};
      3'd4:    w = '{op: OP_EMIT, sel: SEL_1000, cond: COND_JUMP,    target: STEP_IDLE};
      default: w = '{op: OP_NOP,  sel: SEL_1000, cond: COND_JUMP,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/signed_value_to_three_digit_display.sv
// Converts a signed value (optionally tenths) into three display digit codes with
// minus, point, degree and Celsius flags. A word is taken when start is high and
// busy is low; its result appears on out_data with out_valid high for exactly one
// cycle and cannot be held off. Digits come from repeated subtraction of 1000, 100
// and 10 by a small microcoded sequencer on the saturated magnitude; busy stays
// high until the strobe. Degree and Celsius flags hold across non-tenths words;
// the Fahrenheit unit bit is written by cfg_we.
module signed_value_to_three_digit_display (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sv3d_pkg::in_t   in_data,
  output logic            out_valid,
  output sv3d_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);
  import sv3d_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  load_en;

  assign load_en = start && !busy && (ctrl.op == OP_LOAD);

  sv3d_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  sv3d_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (load_en),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: sv/sv3d_seq.sv
module sv3d_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sv3d_pkg::stat_t  stat,
  output sv3d_pkg::ctrl_t  ctrl,
  output logic             busy
);
  import sv3d_pkg::*;

  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;
  logic              taken;

  assign ctrl = rom_word(pc_r);
  assign busy = (pc_r != STEP_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:    taken = 1'b0;
      COND_JUMP:    taken = 1'b1;
      COND_NOSTART: taken = !start;
      COND_GE:      taken = stat.ge;
      default:      taken = 1'b0;
    endcase
    pc_nxt = taken ? ctrl.target : pc_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: sv/sv3d_dp.sv
module sv3d_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_en,
  input  sv3d_pkg::in_t    in_data,
  input  sv3d_pkg::ctrl_t  ctrl,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  output sv3d_pkg::stat_t  stat,
  output logic             out_valid,
  output sv3d_pkg::out_t   out_data
);
  import sv3d_pkg::*;

  logic             unit_r;
  logic             deg_r;
  logic             cel_r;
  logic             valid_r;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;
  logic             tenths_r;
  logic [DIG_W-1:0] d3_r;
  logic [DIG_W-1:0] d2_r;
  logic [DIG_W-1:0] d1_r;
  out_t             out_r;

  logic [14:0]      abs_v;
  logic [MAG_W-1:0] sat_v;
  logic [MAG_W-1:0] k_v;
  logic             big;
  logic [DIG_W-1:0] h_v;
  logic [DIG_W-1:0] t_v;
  logic [DIG_W-1:0] o_v;
  logic             pt_v;

  // magnitude with saturation
  always_comb begin
    abs_v = in_data.value[14] ? (15'd0 - $unsigned(in_data.value))
                              : $unsigned(in_data.value);
    sat_v = (abs_v > 15'(MAG_LIMIT)) ? MAG_LIMIT : abs_v[MAG_W-1:0];
  end

  always_comb begin
    case (ctrl.sel)
      SEL_1000: k_v = K_1000;
      SEL_100:  k_v = K_100;
      default:  k_v = K_10;
    endcase
    stat.ge = (mag_r >= k_v);
  end

  // large magnitudes drop the last digit
  always_comb begin
    big  = (d3_r != '0);
    h_v  = big ? d3_r : d2_r;
    t_v  = big ? d2_r : d1_r;
    o_v  = big ? d1_r : mag_r[DIG_W-1:0];
    pt_v = big ? 1'b0 : tenths_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r  <= 1'b0;
      deg_r   <= 1'b0;
      cel_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unit_r <= cfg_wdata;
      end
      if (load_en && in_data.is_tenths) begin
        deg_r <= 1'b1;
        cel_r <= !unit_r;
      end
      valid_r <= (ctrl.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      mag_r    <= sat_v;
      neg_r    <= in_data.value[14];
      tenths_r <= in_data.is_tenths;
      d3_r     <= '0;
      d2_r     <= '0;
      d1_r     <= '0;
    end else if (ctrl.op == OP_SUB && stat.ge) begin
      mag_r <= mag_r - k_v;
      case (ctrl.sel)
        SEL_1000: d3_r <= d3_r + DIG_W'(1);
        SEL_100:  d2_r <= d2_r + DIG_W'(1);
        default:  d1_r <= d1_r + DIG_W'(1);
      endcase
    end
    if (ctrl.op == OP_EMIT) begin
      out_r.minus_on      <= neg_r;
      out_r.hundreds_code <= (h_v != '0) ? h_v : BLANK_CODE;
      out_r.tens_code     <= (t_v != '0 || h_v != '0 || pt_v) ? t_v : BLANK_CODE;
      out_r.ones_digit    <= o_v;
      out_r.point_on      <= pt_v;
      out_r.degree_on     <= deg_r;
      out_r.celsius_on    <= cel_r;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule
